FILE: design/isma_pkg.sv
// Shared types and constants for the interval-sampled moving average unit.
// Self-contained; the top level refers to it by scoped names.
`timescale 1ns / 1ps

package isma_pkg;

  // Default sizing of the sample window and converter samples.
  localparam int WINDOW_DEF      = 16;
  localparam int SAMPLE_BITS_DEF = 10;

  // Fixed field widths.
  localparam int TIME_W    = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int OUT_W     = 26;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Q8        = 2'd1;

  // Configuration reset values.
  localparam logic [CFG_W-1:0] SAMPLE_INTERVAL_RST = 16'd100;
  localparam logic [CFG_W-1:0] SCALE_Q8_RST        = 16'd256;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

FILE: design/interval_sampled_moving_average_unit.sv
// Top level of the interval-sampled moving average unit: window store, running sum,
// bit-serial multiplier and bit-serial restoring divider. Depends on isma_pkg.
`timescale 1ns / 1ps

//  Channel | Direction | Handshake            | Payload
//  in_     | input     | in_valid / in_ready   | in_timestamp, in_sample, in_send_request
//  out_    | output    | out_valid / out_ready | out_average_valid, out_scaled_average
//  cfg_    | input     | cfg_we                | cfg_index, cfg_wdata
//
// A beat without a send request passes through accept and window update; one with a send
// also runs the multiplier and then the divider, one divider cycle per product bit, or goes
// straight to the result when the window is still empty and the arithmetic is skipped.
// Reset is synchronous; it clears the sum, fill count, write position and time stamp.
// The finished result waits in the output register, so a stalled out_ready blocks
// input only once a second result is ready to be stored.
module interval_sampled_moving_average_unit #(
  parameter int WINDOW      = isma_pkg::WINDOW_DEF,
  parameter int SAMPLE_BITS = isma_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [isma_pkg::TIME_W-1:0]    in_timestamp,
  input  logic [SAMPLE_BITS-1:0]         in_sample,
  input  logic                           in_send_request,
  // Result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_average_valid,
  output logic [isma_pkg::OUT_W-1:0]     out_scaled_average,
  // Configuration port
  input  logic                           cfg_we,
  input  logic [isma_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [isma_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int TIME_W  = isma_pkg::TIME_W;
  localparam int CFG_W   = isma_pkg::CFG_W;
  localparam int OUT_W   = isma_pkg::OUT_W;
  localparam int POS_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W   = $clog2(WINDOW + 1);
  localparam int SUM_W   = $clog2(WINDOW * ((1 << SAMPLE_BITS) - 1) + 1);
  localparam int PROD_W  = SUM_W + CFG_W;
  localparam int ITER_W  = $clog2(PROD_W);
  localparam int EXT_W   = (PROD_W > OUT_W) ? PROD_W : OUT_W;

  // Control state
  isma_pkg::state_t state_r, state_nxt;

  // Configuration registers
  logic [CFG_W-1:0]       interval_r, interval_nxt;
  logic [CFG_W-1:0]       scale_r, scale_nxt;

  // Window state
  logic [TIME_W-1:0]      last_time_r, last_time_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic [CNT_W-1:0]       fill_r, fill_nxt;
  logic [SAMPLE_BITS-1:0] store_mem [WINDOW];
  logic [SAMPLE_BITS-1:0] rd_data_r;

  // Latched beat
  logic [TIME_W-1:0]      ts_r, ts_nxt;
  logic [SAMPLE_BITS-1:0] smp_r, smp_nxt;
  logic                   send_r, send_nxt;
  logic                   take_r, take_nxt;

  // Serial arithmetic
  logic [PROD_W-1:0]      prod_r, prod_nxt;
  logic [CFG_W-1:0]       scl_r, scl_nxt;
  logic [CNT_W-1:0]       rem_r, rem_nxt;
  logic [ITER_W-1:0]      iter_r, iter_nxt;
  logic                   res_valid_r, res_valid_nxt;

  // Output register
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_avg_valid_r, out_avg_valid_nxt;
  logic [OUT_W-1:0]       out_avg_r, out_avg_nxt;

  // Sequencer outputs
  logic                   in_accept;
  logic                   out_load;

  // Helper values
  logic [TIME_W-1:0]      elapsed;
  logic [SAMPLE_BITS-1:0] old_smp;
  logic [CNT_W:0]         partial;
  logic                   div_ge;
  logic [CNT_W:0]         partial_sub;
  logic [EXT_W-1:0]       quot_ext;
  logic                   quot_sat;
  logic                   store_we;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      isma_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = isma_pkg::ST_UPDATE;
      end
      isma_pkg::ST_UPDATE: begin
        if (!send_r) begin
          state_nxt = isma_pkg::ST_IDLE;
        end else if (fill_nxt == '0) begin
          state_nxt = isma_pkg::ST_DONE;
        end else begin
          state_nxt = isma_pkg::ST_MUL;
        end
      end
      isma_pkg::ST_MUL: begin
        if (iter_r == '0) state_nxt = isma_pkg::ST_DIV;
      end
      isma_pkg::ST_DIV: begin
        if (iter_r == '0) state_nxt = isma_pkg::ST_DONE;
      end
      isma_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = isma_pkg::ST_IDLE;
      end
      default: state_nxt = isma_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    case (state_r)
      isma_pkg::ST_IDLE: in_ready = 1'b1;
      isma_pkg::ST_DONE: out_load = !out_valid_r || out_ready;
      default: begin
        in_ready = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  assign in_accept = in_valid && in_ready;

  // Elapsed time since the last taken sample, modulo 2^32.
  assign elapsed = in_timestamp - last_time_r;

  // Entries not yet written since reset read as zero.
  assign old_smp = (fill_r < CNT_W'(WINDOW)) ? '0 : rd_data_r;

  // One restoring division step: bring down the next product bit.
  assign partial     = {rem_r, prod_r[PROD_W-1]};
  assign div_ge      = partial >= {1'b0, fill_r};
  assign partial_sub = partial - {1'b0, fill_r};

  // Saturate the quotient to the result width.
  assign quot_ext = EXT_W'(prod_r);
  assign quot_sat = |(quot_ext >> OUT_W);

  assign store_we = (state_r == isma_pkg::ST_UPDATE) && take_r;

  // Configuration writes.
  always_comb begin
    interval_nxt = interval_r;
    scale_nxt    = scale_r;
    if (cfg_we) begin
      case (cfg_index)
        isma_pkg::REG_SAMPLE_INTERVAL: interval_nxt = cfg_wdata;
        isma_pkg::REG_SCALE_Q8:        scale_nxt    = cfg_wdata;
        default: begin
          interval_nxt = interval_r;
          scale_nxt    = scale_r;
        end
      endcase
    end
  end

  // Datapath next values.
  always_comb begin
    last_time_nxt     = last_time_r;
    sum_nxt           = sum_r;
    pos_nxt           = pos_r;
    fill_nxt          = fill_r;
    ts_nxt            = ts_r;
    smp_nxt           = smp_r;
    send_nxt          = send_r;
    take_nxt          = take_r;
    prod_nxt          = prod_r;
    scl_nxt           = scl_r;
    rem_nxt           = rem_r;
    iter_nxt          = iter_r;
    res_valid_nxt     = res_valid_r;
    out_valid_nxt     = out_valid_r && !out_ready;
    out_avg_valid_nxt = out_avg_valid_r;
    out_avg_nxt       = out_avg_r;

    // Capture the beat and decide whether its sample is taken.
    if (in_accept) begin
      ts_nxt   = in_timestamp;
      smp_nxt  = in_sample;
      send_nxt = in_send_request;
      take_nxt = elapsed >= TIME_W'(interval_r);
    end

    // Window update, then set up the serial multiply.
    if (state_r == isma_pkg::ST_UPDATE) begin
      if (take_r) begin
        last_time_nxt = ts_r;
        sum_nxt       = sum_r - SUM_W'(old_smp) + SUM_W'(smp_r);
        pos_nxt       = (pos_r == POS_W'(WINDOW - 1)) ? '0 : pos_r + 1'b1;
        if (fill_r < CNT_W'(WINDOW)) fill_nxt = fill_r + 1'b1;
      end
      prod_nxt      = '0;
      rem_nxt       = '0;
      scl_nxt       = scale_r;
      iter_nxt      = ITER_W'(CFG_W - 1);
      res_valid_nxt = fill_nxt != '0;
    end

    // Shift-add multiply, scale bits taken MSB first.
    if (state_r == isma_pkg::ST_MUL) begin
      prod_nxt = {prod_r[PROD_W-2:0], 1'b0} + (scl_r[CFG_W-1] ? PROD_W'(sum_r) : '0);
      scl_nxt  = {scl_r[CFG_W-2:0], 1'b0};
      iter_nxt = (iter_r == '0) ? ITER_W'(PROD_W - 1) : iter_r - 1'b1;
    end

    // Restoring divide by the fill count; quotient bits shift in at the bottom.
    if (state_r == isma_pkg::ST_DIV) begin
      rem_nxt  = div_ge ? partial_sub[CNT_W-1:0] : partial[CNT_W-1:0];
      prod_nxt = {prod_r[PROD_W-2:0], div_ge};
      iter_nxt = iter_r - 1'b1;
    end

    // Move the finished result into the output register.
    if (out_load) begin
      out_valid_nxt     = 1'b1;
      out_avg_valid_nxt = res_valid_r;
      out_avg_nxt       = quot_sat ? '1 : quot_ext[OUT_W-1:0];
    end
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= isma_pkg::ST_IDLE;
      interval_r  <= isma_pkg::SAMPLE_INTERVAL_RST;
      scale_r     <= isma_pkg::SCALE_Q8_RST;
      last_time_r <= '0;
      sum_r       <= '0;
      pos_r       <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      interval_r  <= interval_nxt;
      scale_r     <= scale_nxt;
      last_time_r <= last_time_nxt;
      sum_r       <= sum_nxt;
      pos_r       <= pos_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    ts_r            <= ts_nxt;
    smp_r           <= smp_nxt;
    send_r          <= send_nxt;
    take_r          <= take_nxt;
    prod_r          <= prod_nxt;
    scl_r           <= scl_nxt;
    rem_r           <= rem_nxt;
    iter_r          <= iter_nxt;
    res_valid_r     <= res_valid_nxt;
    out_avg_valid_r <= out_avg_valid_nxt;
    out_avg_r       <= out_avg_nxt;
  end

  // Window store: one write port, registered read at the write position.
  always_ff @(posedge clk) begin
    if (store_we) store_mem[pos_r] <= smp_r;
    rd_data_r <= store_mem[pos_r];
  end

  assign out_valid          = out_valid_r;
  assign out_average_valid  = out_avg_valid_r;
  assign out_scaled_average = out_avg_r;

endmodule
